>>> sv/ptt_pkg.sv
// Shared types, codes and defaults of the programmable transition table state machine.
`timescale 1ns / 1ps

package ptt_pkg;

  localparam int unsigned ENTRIES_DEF    = 32;
  localparam int unsigned STATE_BITS_DEF = 8;
  localparam int unsigned EVENT_BITS_DEF = 8;

  localparam int unsigned BEGIN_STATE     = 1;
  localparam int unsigned CATCH_ALL_EVENT = 0;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned FIELD_W  = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned IN_W     = 32;
  localparam int unsigned OUT_W    = 32;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_EVENT  = 2'd1,
    OP_RESET  = 2'd2
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_CONFLICT  = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_ACT_FAIL  = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_last;
    logic out_free;
  } dp_stat_t;

endpackage

>>> sv/ptt_ctrl.sv
// Sequencer that steps one beat through load, table scan and result write-back.
`timescale 1ns / 1ps

module ptt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  ptt_pkg::dp_stat_t   stat_i,
  output ptt_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_LAST = 4'b0100,
    S_DONE = 4'b1000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_ready_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_ready_o  = 1'b1;
        cmd_o.load = s_valid_i;
        if (s_valid_i) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = stat_i.need_scan;
        if (!stat_i.need_scan) begin
          state_d = S_DONE;
        end else if (stat_i.scan_last) begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        cmd_o.finish = stat_i.out_free;
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> stat_i.out_free)
    else $error("result written while output register busy");

  a_scan_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == S_SCAN))
    else $error("load not followed by scan phase");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

endmodule

>>> sv/ptt_dp.sv
// Datapath: item register, transition table memory, scan compare, resolve and output register.
`timescale 1ns / 1ps

module ptt_dp #(
  parameter int unsigned ENTRIES    = ptt_pkg::ENTRIES_DEF,
  parameter int unsigned STATE_BITS = ptt_pkg::STATE_BITS_DEF,
  parameter int unsigned EVENT_BITS = ptt_pkg::EVENT_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ptt_pkg::ctrl_cmd_t          cmd_i,
  output ptt_pkg::dp_stat_t           stat_o,
  input  logic [ptt_pkg::IN_W-1:0]    in_data_i,
  input  logic [ptt_pkg::OP_W-1:0]    in_op_i,
  output logic                        m_valid_o,
  input  logic                        m_ready_i,
  output logic [ptt_pkg::OUT_W-1:0]   m_data_o
);

  localparam int unsigned SB    = STATE_BITS;
  localparam int unsigned EB    = EVENT_BITS;
  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned ENT_W = 2 * SB + EB + 1;
  localparam int unsigned FW    = ptt_pkg::FIELD_W;

  logic [ENT_W-1:0] mem_q [ENTRIES];
  logic [ENT_W-1:0] rd_q;

  logic [ptt_pkg::OP_W-1:0] op_q;
  logic [EB-1:0]            evt_q;
  logic [SB-1:0]            src_q;
  logic [SB-1:0]            dst_q;
  logic                     has_act_q;
  logic                     act_ok_q;

  logic [SB-1:0]    state_q;
  logic [CNT_W-1:0] used_q;
  logic [CNT_W-1:0] cnt_q;
  logic             cmp_en_q;

  logic             ex_hit_q, def_hit_q;
  logic [SB-1:0]    ex_dst_q, def_dst_q;
  logic             ex_act_q, def_act_q;

  logic             m_valid_q;
  logic [ptt_pkg::OUT_W-1:0] m_data_q;

  logic [SB-1:0]    key_src;
  logic [SB-1:0]    rd_src, rd_dst;
  logic [EB-1:0]    rd_evt;
  logic             rd_act;

  ptt_pkg::status_e res_status;
  logic [SB-1:0]    res_state;
  logic [EB-1:0]    res_taken;
  logic [SB-1:0]    res_target;
  logic             res_called;
  logic             tbl_wr;
  logic             table_full;

  assign {rd_act, rd_dst, rd_evt, rd_src} = rd_q;
  assign key_src    = (op_q == ptt_pkg::OP_INSERT) ? src_q : state_q;
  assign table_full = (used_q == CNT_W'(ENTRIES));

  assign stat_o.need_scan = (used_q != '0) &&
                            ((op_q == ptt_pkg::OP_INSERT) || (op_q == ptt_pkg::OP_EVENT));
  assign stat_o.scan_last = ((cnt_q + CNT_W'(1)) == used_q);
  assign stat_o.out_free  = !m_valid_q || m_ready_i;

  always_comb begin
    res_status = ptt_pkg::ST_OK;
    res_state  = state_q;
    res_taken  = '0;
    res_target = '0;
    res_called = 1'b0;
    tbl_wr     = 1'b0;
    case (op_q)
      ptt_pkg::OP_INSERT: begin
        if (ex_hit_q) begin
          res_status = ptt_pkg::ST_CONFLICT;
        end else if (table_full) begin
          res_status = ptt_pkg::ST_FULL;
        end else begin
          tbl_wr = 1'b1;
        end
      end
      ptt_pkg::OP_EVENT: begin
        if (ex_hit_q || def_hit_q) begin
          res_taken  = ex_hit_q ? evt_q : EB'(ptt_pkg::CATCH_ALL_EVENT);
          res_target = ex_hit_q ? ex_dst_q : def_dst_q;
          res_called = ex_hit_q ? ex_act_q : def_act_q;
          if (res_called && !act_ok_q) begin
            res_status = ptt_pkg::ST_ACT_FAIL;
          end else begin
            res_state = res_target;
          end
        end else begin
          res_status = ptt_pkg::ST_NOT_FOUND;
        end
      end
      ptt_pkg::OP_RESET: begin
        res_state = SB'(ptt_pkg::BEGIN_STATE);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && tbl_wr) begin
      mem_q[used_q[IDX_W-1:0]] <= {has_act_q, dst_q, evt_q, src_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      rd_q <= mem_q[cnt_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= in_op_i;
      evt_q     <= EB'(in_data_i[FW-1:0]);
      src_q     <= SB'(in_data_i[2*FW-1:FW]);
      dst_q     <= SB'(in_data_i[3*FW-1:2*FW]);
      has_act_q <= in_data_i[3*FW];
      act_ok_q  <= in_data_i[3*FW+1];
    end
    if (cmp_en_q && (rd_src == key_src)) begin
      if (rd_evt == evt_q) begin
        ex_dst_q <= rd_dst;
        ex_act_q <= rd_act;
      end
      if (rd_evt == EB'(ptt_pkg::CATCH_ALL_EVENT)) begin
        def_dst_q <= rd_dst;
        def_act_q <= rd_act;
      end
    end
    if (cmd_i.finish) begin
      m_data_q <= ptt_pkg::OUT_W'({res_called, FW'(res_target), FW'(res_taken),
                                   FW'(res_state), res_status});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SB'(ptt_pkg::BEGIN_STATE);
      used_q    <= '0;
      cnt_q     <= '0;
      cmp_en_q  <= 1'b0;
      ex_hit_q  <= 1'b0;
      def_hit_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      cmp_en_q <= cmd_i.scan;
      if (cmd_i.load) begin
        cnt_q     <= '0;
        ex_hit_q  <= 1'b0;
        def_hit_q <= 1'b0;
      end else begin
        if (cmd_i.scan) begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
        if (cmp_en_q && (rd_src == key_src)) begin
          if (rd_evt == evt_q) begin
            ex_hit_q <= 1'b1;
          end
          if (rd_evt == EB'(ptt_pkg::CATCH_ALL_EVENT)) begin
            def_hit_q <= 1'b1;
          end
        end
      end
      if (cmd_i.finish) begin
        state_q   <= res_state;
        m_valid_q <= 1'b1;
        if (tbl_wr) begin
          used_q <= used_q + CNT_W'(1);
        end
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(ENTRIES))
    else $error("fill count beyond table depth");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan |-> (cnt_q < used_q))
    else $error("scan read past filled entries");

  a_write_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && tbl_wr) |-> (!table_full && !ex_hit_q))
    else $error("table write on full table or duplicate key");

  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> m_valid_q)
    else $error("finished beat not presented");

endmodule

>>> sv/programmable_transition_table_fsm_core.sv
// Top level of the programmable transition table state machine.
`timescale 1ns / 1ps
// Usage:
//   Slave channel s_axis_*: one beat per command. tuser carries the opcode
//   (insert transition, apply event, reset state). tdata carries the event,
//   from-state, to-state, action flag and action result.
//   Master channel m_axis_*: one result beat per command, with status,
//   current state, matched event, target state and action-called flag.
// Timing: an insert or event beat scans the filled table entries (at most
//   ENTRIES), one entry per cycle through the table memory read port, before
//   the result is written to the output register. Reset-state and unused
//   opcodes, and any beat on an empty table, skip the scan. A new beat is
//   taken in the cycle after the previous one has been written to the output
//   register.
// Reset: the table is empty and the state is 1, the begin state.
// Stall: the result waits in the output register; one more beat is
//   accepted and processed, then held until the output register frees.

module programmable_transition_table_fsm_core #(
  parameter int unsigned ENTRIES    = ptt_pkg::ENTRIES_DEF,
  parameter int unsigned STATE_BITS = ptt_pkg::STATE_BITS_DEF,
  parameter int unsigned EVENT_BITS = ptt_pkg::EVENT_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // event_code[7:0], from_state[15:8], to_state[23:16], has_action[24], action_ok[25]
  input  logic [ptt_pkg::IN_W-1:0]   s_axis_tdata,
  // opcode[1:0]
  input  logic [ptt_pkg::OP_W-1:0]   s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // status[2:0], current_state[10:3], taken_event[18:11], target_state[26:19],
  // action_called[27]
  output logic [ptt_pkg::OUT_W-1:0]  m_axis_tdata
);

  ptt_pkg::ctrl_cmd_t cmd;
  ptt_pkg::dp_stat_t  stat;

  ptt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  ptt_dp #(
    .ENTRIES    (ENTRIES),
    .STATE_BITS (STATE_BITS),
    .EVENT_BITS (EVENT_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .in_data_i (s_axis_tdata),
    .in_op_i   (s_axis_tuser),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata)
  );

endmodule

>>> bench/testbench.sv
// Self-checking testbench of the programmable transition table state machine.
`timescale 1ns / 1ps

module testbench;
  import ptt_pkg::*;

  localparam int unsigned N_RULES    = ENTRIES_DEF;
  localparam int          N_RANDOM   = 1000;
  localparam int          IDLE_LIMIT = 3000;
  localparam int          DRAIN      = 40;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [FIELD_W-1:0] evt;
    logic [FIELD_W-1:0] src;
    logic [FIELD_W-1:0] dst;
    logic               act;
    logic               ok;
  } command_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  cur;
    logic [FIELD_W-1:0]  taken;
    logic [FIELD_W-1:0]  target;
    logic                called;
  } outcome_t;

  typedef struct packed {
    command_t cmd;
    logic     given;
    outcome_t res;
  } row_t;

  typedef struct packed {
    logic     given;
    outcome_t res;
  } typed_t;

  typedef struct packed {
    logic               valid;
    logic [FIELD_W-1:0] src;
    logic [FIELD_W-1:0] evt;
    logic [FIELD_W-1:0] dst;
    logic               act;
  } rule_t;

  localparam int N_DIRECTED = 19;
  localparam row_t DIRECTED [N_DIRECTED] = '{
    '{'{OP_EVENT,  8'h05, 8'h00, 8'h00, 1'b0, 1'b1}, 1'b1, '{ST_NOT_FOUND, 8'd1, 8'd0, 8'd0, 1'b0}},
    '{'{OP_INSERT, 8'h05, 8'h01, 8'h02, 1'b0, 1'b0}, 1'b1, '{ST_OK,        8'd1, 8'd0, 8'd0, 1'b0}},
    '{'{OP_INSERT, 8'h05, 8'h01, 8'h09, 1'b1, 1'b0}, 1'b1, '{ST_CONFLICT,  8'd1, 8'd0, 8'd0, 1'b0}},
    '{'{OP_INSERT, 8'h00, 8'h02, 8'hFF, 1'b1, 1'b0}, 1'b1, '{ST_OK,        8'd1, 8'd0, 8'd0, 1'b0}},
    '{'{OP_INSERT, 8'hFF, 8'hFF, 8'h00, 1'b1, 1'b0}, 1'b1, '{ST_OK,        8'd1, 8'd0, 8'd0, 1'b0}},
    '{'{OP_INSERT, 8'hFF, 8'h00, 8'h01, 1'b0, 1'b1}, 1'b1, '{ST_OK,        8'd1, 8'd0, 8'd0, 1'b0}},
    '{'{OP_EVENT,  8'h05, 8'h00, 8'h00, 1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_EVENT,  8'h4D, 8'h00, 8'h00, 1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_EVENT,  8'h4D, 8'h00, 8'h00, 1'b0, 1'b1}, 1'b0, '0},
    '{'{OP_EVENT,  8'hFF, 8'h00, 8'h00, 1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_EVENT,  8'hFF, 8'h00, 8'h00, 1'b0, 1'b1}, 1'b0, '0},
    '{'{OP_EVENT,  8'hFF, 8'h00, 8'h00, 1'b1, 1'b1}, 1'b0, '0},
    '{'{OP_EVENT,  8'h03, 8'h00, 8'h00, 1'b0, 1'b1}, 1'b1, '{ST_NOT_FOUND, 8'd1, 8'd0, 8'd0, 1'b0}},
    '{'{OP_INSERT, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1}, 1'b1, '{ST_CONFLICT,  8'd1, 8'd0, 8'd0, 1'b0}},
    '{'{OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1}, 1'b1, '{ST_OK,        8'd1, 8'd0, 8'd0, 1'b0}},
    '{'{OP_EVENT,  8'h05, 8'h00, 8'h00, 1'b0, 1'b1}, 1'b0, '0},
    '{'{OP_RESET,  8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1}, 1'b1, '{ST_OK,        8'd1, 8'd0, 8'd0, 1'b0}},
    '{'{OP_INSERT, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0}, 1'b1, '{ST_OK,        8'd1, 8'd0, 8'd0, 1'b0}},
    '{'{OP_UNUSED, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0}, 1'b1, '{ST_OK,        8'd1, 8'd0, 8'd0, 1'b0}}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [IN_W-1:0]     s_axis_tdata;
  logic [OP_W-1:0]     s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OUT_W-1:0]    m_axis_tdata;

  rule_t               rules [N_RULES];
  int unsigned         rules_used;
  logic [FIELD_W-1:0]  fsm_state;

  outcome_t            pending_results [$];
  typed_t              typed_q [$];
  int                  fails;
  bit                  s_calm;
  bit                  m_calm;

  programmable_transition_table_fsm_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic int rule_index(logic [FIELD_W-1:0] src, logic [FIELD_W-1:0] evt);
    for (int i = 0; i < N_RULES; i++) begin
      if (rules[i].valid && rules[i].src == src && rules[i].evt == evt) return i;
    end
    return -1;
  endfunction

  function automatic outcome_t fsm_step(command_t c);
    outcome_t o;
    int       idx;
    o = '0;
    o.status = ST_OK;
    if (c.op == OP_INSERT) begin
      if (rule_index(c.src, c.evt) >= 0) begin
        o.status = ST_CONFLICT;
      end else if (rules_used >= N_RULES) begin
        o.status = ST_FULL;
      end else begin
        rules[rules_used] = '{1'b1, c.src, c.evt, c.dst, c.act};
        rules_used++;
      end
    end else if (c.op == OP_EVENT) begin
      idx = rule_index(fsm_state, c.evt);
      if (idx < 0) idx = rule_index(fsm_state, FIELD_W'(CATCH_ALL_EVENT));
      if (idx < 0) begin
        o.status = ST_NOT_FOUND;
      end else begin
        o.taken  = rules[idx].evt;
        o.target = rules[idx].dst;
        o.called = rules[idx].act;
        if (rules[idx].act && !c.ok) o.status = ST_ACT_FAIL;
        else fsm_state = rules[idx].dst;
      end
    end else if (c.op == OP_RESET) begin
      fsm_state = FIELD_W'(BEGIN_STATE);
    end
    o.cur = fsm_state;
    return o;
  endfunction

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [FIELD_W-1:0] pick_state();
    if ($urandom_range(0, 9) < 8) return FIELD_W'($urandom_range(0, 7));
    return FIELD_W'($urandom);
  endfunction

  function automatic logic [FIELD_W-1:0] pick_event();
    if ($urandom_range(0, 9) < 8) return FIELD_W'($urandom_range(0, 3));
    return FIELD_W'($urandom);
  endfunction

  // Bias toward events so the machine walks the stored graph; keep some noise.
  function automatic command_t random_command();
    command_t c;
    int       r;
    r      = $urandom_range(0, 99);
    c.evt  = pick_event();
    c.src  = pick_state();
    c.dst  = pick_state();
    c.act  = 1'($urandom);
    c.ok   = ($urandom_range(0, 9) < 7);
    if (r < 28)      c.op = OP_INSERT;
    else if (r < 90) c.op = OP_EVENT;
    else if (r < 97) c.op = OP_RESET;
    else             c.op = OP_UNUSED;
    return c;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      fails++;
      $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endtask

  initial begin
    rules_used = 0;
    fsm_state  = FIELD_W'(BEGIN_STATE);
    fails      = 0;
    s_calm     = 1'b0;
    m_calm     = 1'b0;
    for (int i = 0; i < N_RULES; i++) rules[i] = '0;
  end

  initial begin : drive_commands
    command_t c;
    typed_t   t;
    int       gap;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    for (int i = 0; i < N_DIRECTED + N_RANDOM; i++) begin
      if (i < N_DIRECTED) begin
        c = DIRECTED[i].cmd;
        t = '{DIRECTED[i].given, DIRECTED[i].res};
      end else begin
        c = random_command();
        t = '0;
      end
      gap = pick_gap(s_calm);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      typed_q.push_back(t);
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= {{(IN_W - 26){1'b0}}, c.ok, c.act, c.dst, c.src, c.evt};
      s_axis_tuser  <= c.op;
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
      if ($urandom_range(0, 39) == 0) s_calm = !s_calm;
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (fails == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : drive_ready
    int stall;
    int run;
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    forever begin
      stall = pick_gap(m_calm);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      run = $urandom_range(1, 8);
      repeat (run) @(posedge clk_i);
      if ($urandom_range(0, 31) == 0) m_calm = !m_calm;
    end
  end

  always @(posedge clk_i) begin : watch_ports
    command_t c;
    outcome_t want;
    outcome_t got;
    typed_t   t;
    if (s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1) begin
      c.evt = s_axis_tdata[7:0];
      c.src = s_axis_tdata[15:8];
      c.dst = s_axis_tdata[23:16];
      c.act = s_axis_tdata[24];
      c.ok  = s_axis_tdata[25];
      c.op  = s_axis_tuser;
      want  = fsm_step(c);
      t     = typed_q.pop_front();
      if (t.given) want = t.res;
      pending_results.push_back(want);
    end
    if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      got.status = m_axis_tdata[2:0];
      got.cur    = m_axis_tdata[10:3];
      got.taken  = m_axis_tdata[18:11];
      got.target = m_axis_tdata[26:19];
      got.called = m_axis_tdata[27];
      if (pending_results.size() == 0) begin
        fails++;
        $error("result beat with no command waiting");
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, got.status);
        check_field("current_state", want.cur, got.cur);
        check_field("taken_event", want.taken, got.taken);
        check_field("target_state", want.target, got.target);
        check_field("action_called", want.called, got.called);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    int idle_cycles;
    if ((s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1) ||
        (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule
